>>> rtl/gdsl_pkg.sv
// Shared types, widths and helpers for the goal distance speed limiter.
// Used by the slowdown unit, the square root cells and the top level.
package gdsl_pkg;

    localparam int VEL_W   = 16;
    localparam int DIST_W  = 21;
    localparam int SPEED_W = 15;
    localparam int DECEL_W = 16;
    localparam int SCALE_W = 16;
    localparam int BUF_W   = 20;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;

    localparam int RAD_W   = 38;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int SLOW_W  = 39;

    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_DECEL = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BUFFER    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN_SPEED = 3'd5;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;

    typedef struct packed {
        logic [SPEED_W-1:0] max_speed;
        logic [DECEL_W-1:0] max_deceleration;
        logic [SCALE_W-1:0] brake_scale;
        logic [BUF_W-1:0]   brake_buffer;
    } slow_cfg_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [VEL_W-1:0]  vel;
        logic              apply;
    } cell_t;

    function automatic logic [DECEL_W-1:0] decel_eff(input logic [DECEL_W-1:0] d);
        decel_eff = (d == '0) ? DECEL_W'(1) : d;
    endfunction

    function automatic logic [SCALE_W-1:0] scale_eff(input logic [SCALE_W-1:0] s);
        scale_eff = (s < SCALE_ONE) ? SCALE_ONE : s;
    endfunction

endpackage

>>> rtl/gdsl_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while en is high.
// Depends on gdsl_pkg for the cell payload type.
module gdsl_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  gdsl_pkg::cell_t cell_in,
    output logic           valid_out,
    output gdsl_pkg::cell_t cell_out
);
    import gdsl_pkg::*;

    logic             valid_reg;
    cell_t            cell_reg;
    cell_t            cell_next;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] sub;
    logic [REM_W+1:0] diff;
    logic             ge;

    always_comb
    begin
        trial = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
        sub   = (REM_W+2)'({cell_in.root, 2'b01});
        diff  = trial - sub;
        ge    = (trial >= sub);
        cell_next       = cell_in;
        cell_next.rad   = {cell_in.rad[RAD_W-3:0], 2'b00};
        cell_next.rem   = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        cell_next.root  = {cell_in.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign valid_out = valid_reg;
    assign cell_out  = cell_reg;

endmodule

>>> rtl/gdsl_slowdown.sv
// Sequential unit that derives the slowdown distance from the configuration.
// Squares, divides bit-serially, multiplies by shift and add; uses gdsl_pkg.
module gdsl_slowdown (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  gdsl_pkg::slow_cfg_t         cfg,
    output logic [gdsl_pkg::SLOW_W-1:0] slowdown,
    output logic                        busy
);
    import gdsl_pkg::*;

    localparam int SQ_W  = 2 * SPEED_W;
    localparam int DEN_W = DECEL_W + 1;
    localparam int ACC_W = SQ_W + SCALE_W;

    typedef enum logic [2:0] {S_SQUARE, S_DIV, S_MUL, S_SUM, S_DONE} state_t;

    state_t            state_reg;
    logic [SQ_W-1:0]   work_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [4:0]        count_reg;
    logic [SLOW_W-1:0] slowdown_reg;

    logic [DEN_W-1:0]   den;
    logic [DEN_W:0]     rem_sh;
    logic               q_bit;
    logic [DEN_W-1:0]   rem_next;
    logic [SCALE_W-1:0] scale;
    logic [ACC_W-1:0]   acc_next;

    always_comb
    begin
        den      = {decel_eff(cfg.max_deceleration), 1'b0};
        rem_sh   = {rem_reg, work_reg[SQ_W-1]};
        q_bit    = (rem_sh >= (DEN_W+1)'(den));
        rem_next = q_bit ? DEN_W'(rem_sh - (DEN_W+1)'(den)) : rem_sh[DEN_W-1:0];
        scale    = scale_eff(cfg.brake_scale);
        acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                   + (scale[count_reg[3:0]] ? ACC_W'(work_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SQUARE;
            count_reg <= '0;
        end
        else if (restart)
        begin
            state_reg <= S_SQUARE;
        end
        else
        begin
            case (state_reg)
                S_SQUARE:
                begin
                    work_reg  <= SQ_W'(cfg.max_speed) * SQ_W'(cfg.max_speed);
                    rem_reg   <= '0;
                    count_reg <= 5'(SQ_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    work_reg <= {work_reg[SQ_W-2:0], q_bit};
                    rem_reg  <= rem_next;
                    if (count_reg == '0)
                    begin
                        acc_reg   <= '0;
                        count_reg <= 5'(SCALE_W - 1);
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        count_reg <= count_reg - 5'd1;
                    end
                end
                S_MUL:
                begin
                    acc_reg <= acc_next;
                    if (count_reg == '0)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        count_reg <= count_reg - 5'd1;
                    end
                end
                S_SUM:
                begin
                    slowdown_reg <= SLOW_W'(acc_reg[ACC_W-1:8]) + SLOW_W'(cfg.brake_buffer);
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_DONE;
                end
                default:
                begin
                    state_reg <= S_SQUARE;
                end
            endcase
        end
    end

    assign slowdown = slowdown_reg;
    assign busy     = (state_reg != S_DONE);

endmodule

>>> rtl/goal_distance_speed_limiter_unit.sv
// Top level of the goal distance speed limiter: registers, input stages,
// the chain of square root cells and the output register. Uses gdsl_pkg.
//
//  channel   direction  signals                        payload
//  s_axis    in         tvalid tready tdata[39:0]      velocity, distance
//  m_axis    out        tvalid tready tdata[15:0] tuser limited velocity, flag
//  cfg       in         cfg_wen cfg_index cfg_data     register writes
//
// One beat is accepted per cycle while s_axis_tready is high; each beat passes
// the input stage, the multiply stage and the 19 square root cells, one root
// bit per cell, on to the output register that drives m_axis_tvalid.
// After reset and after every configuration write the slowdown unit runs with
// s_axis_tready low. All stages stall together while the output register holds
// a beat that m_axis has not taken.
module goal_distance_speed_limiter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // desired velocity [15:0], goal distance [36:16], zero fill [39:37]
    input  logic [39:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // limited_velocity [15:0]
    output logic [15:0]                   m_axis_tdata,
    // was_limited [0]
    output logic [0:0]                    m_axis_tuser,
    input  logic                          cfg_wen,
    input  logic [gdsl_pkg::IDX_W-1:0]    cfg_index,
    input  logic [gdsl_pkg::CFG_W-1:0]    cfg_data
);
    import gdsl_pkg::*;

    logic               enable_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [DECEL_W-1:0] max_decel_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [BUF_W-1:0]   buffer_reg;
    logic [SPEED_W-1:0] min_speed_reg;

    slow_cfg_t          slow_cfg;
    logic [SLOW_W-1:0]  slowdown;
    logic               busy;
    logic               adv;
    logic               accept;

    logic               valid_a_reg;
    logic [VEL_W-1:0]   vel_a_reg;
    logic [BUF_W-1:0]   dist_a_reg;
    logic               apply_a_reg;
    logic [DIST_W-1:0]  dist_in;
    logic               apply_next;

    logic               valid_b_reg;
    logic [RAD_W-1:0]   rad_b_reg;
    logic [VEL_W-1:0]   vel_b_reg;
    logic               apply_b_reg;

    logic               chain_v [0:ROOT_W];
    cell_t              chain_d [0:ROOT_W];

    logic               out_valid_reg;
    logic [VEL_W-1:0]   out_vel_reg;
    logic               out_flag_reg;

    cell_t              last;
    logic [VEL_W:0]     vel_ext;
    logic [VEL_W:0]     speed;
    logic [VEL_W:0]     lim;
    logic [VEL_W-1:0]   vel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            max_speed_reg <= 15'd1000;
            max_decel_reg <= 16'd500;
            scale_reg     <= SCALE_ONE;
            buffer_reg    <= '0;
            min_speed_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ENABLE:    enable_reg    <= cfg_data[0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data[SPEED_W-1:0];
                REG_MAX_DECEL: max_decel_reg <= cfg_data[DECEL_W-1:0];
                REG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_BUFFER:    buffer_reg    <= cfg_data[BUF_W-1:0];
                REG_MIN_SPEED: min_speed_reg <= cfg_data[SPEED_W-1:0];
                default:       enable_reg    <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        slow_cfg.max_speed        = max_speed_reg;
        slow_cfg.max_deceleration = max_decel_reg;
        slow_cfg.brake_scale      = scale_reg;
        slow_cfg.brake_buffer     = buffer_reg;
    end

    gdsl_slowdown u_slowdown (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_wen),
        .cfg      (slow_cfg),
        .slowdown (slowdown),
        .busy     (busy)
    );

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        dist_in    = s_axis_tdata[VEL_W +: DIST_W];
        apply_next = enable_reg && !dist_in[DIST_W-1]
                     && (SLOW_W'(dist_in[BUF_W-1:0]) <= slowdown);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg   <= accept;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= chain_v[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vel_a_reg   <= s_axis_tdata[VEL_W-1:0];
            dist_a_reg  <= dist_in[BUF_W-1:0];
            apply_a_reg <= apply_next;
            rad_b_reg   <= RAD_W'({decel_eff(max_decel_reg), 1'b0}) * RAD_W'(dist_a_reg);
            vel_b_reg   <= vel_a_reg;
            apply_b_reg <= apply_a_reg;
            out_vel_reg <= vel_next;
            out_flag_reg <= last.apply;
        end
    end

    always_comb
    begin
        chain_v[0]       = valid_b_reg;
        chain_d[0].rad   = rad_b_reg;
        chain_d[0].rem   = '0;
        chain_d[0].root  = '0;
        chain_d[0].vel   = vel_b_reg;
        chain_d[0].apply = apply_b_reg;
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        gdsl_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (chain_v[i]),
            .cell_in   (chain_d[i]),
            .valid_out (chain_v[i+1]),
            .cell_out  (chain_d[i+1])
        );
    end

    always_comb
    begin
        last    = chain_d[ROOT_W];
        vel_ext = {last.vel[VEL_W-1], last.vel};
        speed   = last.vel[VEL_W-1] ? ((VEL_W+1)'(0) - vel_ext) : vel_ext;
        lim     = (ROOT_W'(speed) > last.root) ? last.root[VEL_W:0] : speed;
        if (lim < (VEL_W+1)'(min_speed_reg))
        begin
            lim = '0;
        end
        if (!last.apply)
        begin
            vel_next = last.vel;
        end
        else if (last.vel[VEL_W-1])
        begin
            vel_next = VEL_W'((VEL_W+1)'(0) - lim);
        end
        else
        begin
            vel_next = lim[VEL_W-1:0];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_vel_reg;
    assign m_axis_tuser[0] = out_flag_reg;

endmodule

>>> verif/tb_goal_distance_speed_limiter_unit.sv
// Testbench for goal_distance_speed_limiter_unit: drives velocity and distance beats,
// rewrites the limiter registers between phases and checks every result beat against
// a scoreboard that predicts the braking-distance speed cap. Needs gdsl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_goal_distance_speed_limiter_unit;
    import gdsl_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int DIST_MAX = 1048575;

    class limiter_scoreboard;
        typedef struct {
            logic [VEL_W-1:0] velocity;
            logic             limited;
        } cmd_result_t;

        bit                 enable;
        bit [SPEED_W-1:0]   vmax;
        bit [DECEL_W-1:0]   decel;
        bit [SCALE_W-1:0]   scale;
        bit [BUF_W-1:0]     buffer;
        bit [SPEED_W-1:0]   vmin;
        cmd_result_t        expected_limits[$];
        int                 mismatches;

        function new();
            enable = 1'b0;
            vmax = 15'd1000;
            decel = 16'd500;
            scale = SCALE_ONE;
            buffer = '0;
            vmin = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_ENABLE:    enable = val[0];
                REG_MAX_SPEED: vmax = val[SPEED_W-1:0];
                REG_MAX_DECEL: decel = val[DECEL_W-1:0];
                REG_SCALE:     scale = val[SCALE_W-1:0];
                REG_BUFFER:    buffer = val[BUF_W-1:0];
                REG_MIN_SPEED: vmin = val[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned eff_decel();
            return (decel == 0) ? 64'd1 : 64'(decel);
        endfunction

        function longint unsigned slowdown_mm();
            longint unsigned vm;
            longint unsigned sc;
            longint unsigned nominal;
            vm = vmax;
            sc = (scale < SCALE_ONE) ? 64'(SCALE_ONE) : 64'(scale);
            nominal = (vm * vm) / (2 * eff_decel());
            return ((nominal * sc) >> 8) + buffer;
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int k = 20; k >= 0; k--) begin
                trial = root | (64'd1 << k);
                if (trial * trial <= x)
                    root = trial;
            end
            return root;
        endfunction

        function cmd_result_t predict_limited_velocity(logic [VEL_W-1:0] vel,
                                                       logic [DIST_W-1:0] range_mm);
            cmd_result_t r;
            longint unsigned d;
            longint unsigned speed;
            longint unsigned cap;
            r.velocity = vel;
            r.limited = 1'b0;
            d = range_mm;
            if (enable && !range_mm[DIST_W-1] && d <= slowdown_mm()) begin
                speed = vel[VEL_W-1] ? (64'd65536 - vel) : 64'(vel);
                cap = floor_root(2 * eff_decel() * d);
                if (cap < speed)
                    speed = cap;
                if (speed < vmin)
                    speed = 0;
                r.velocity = vel[VEL_W-1] ? 16'(64'd65536 - speed) : 16'(speed);
                r.limited = 1'b1;
            end
            return r;
        endfunction

        function void note_command(logic [VEL_W-1:0] vel, logic [DIST_W-1:0] range_mm);
            expected_limits.push_back(predict_limited_velocity(vel, range_mm));
        endfunction

        function void check_result(logic [VEL_W-1:0] vel, logic limited);
            cmd_result_t e;
            if (expected_limits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: vel %0d limited %0b",
                             $signed(vel), limited);
                return;
            end
            e = expected_limits.pop_front();
            if (e.velocity !== vel || e.limited !== limited) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected vel %0d limited %0b, got vel %0d limited %0b",
                             $signed(e.velocity), e.limited, $signed(vel), limited);
            end
        endfunction

        function int pending();
            return expected_limits.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;
    logic [0:0]         m_axis_tuser;
    logic               cfg_wen;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    bit                 full_rate = 1'b0;
    bit                 hold_req = 1'b0;
    limiter_scoreboard  sb = new();

    goal_distance_speed_limiter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic int pick_velocity();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return int'($urandom_range(0, 65535));
        else if (sel < 90)
            return int'($urandom_range(0, 400)) - 200;
        else if (sel < 95)
            return 32767;
        else
            return -32768;
    endfunction

    function automatic int pick_distance(longint unsigned slowdown);
        int unsigned sel;
        longint lim;
        longint d;
        sel = $urandom_range(0, 99);
        lim = (slowdown > DIST_MAX) ? DIST_MAX : longint'(slowdown);
        if (sel < 50) begin
            d = $urandom_range(0, int'(lim));
        end else if (sel < 60) begin
            d = lim + $urandom_range(0, 4) - 2;
            if (d < 0)
                d = 0;
            if (d > DIST_MAX)
                d = DIST_MAX;
        end else if (sel < 75) begin
            d = $urandom_range(0, 2 * DIST_MAX + 1);
        end else if (sel < 85) begin
            d = -longint'($urandom_range(1, DIST_MAX + 1));
        end else begin
            d = $urandom_range(0, 100);
        end
        return int'(d);
    endfunction

    function automatic int pick_field(int unsigned hi, int unsigned usual_hi);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return 0;
        else if (sel < 15)
            return hi;
        else if (sel < 60)
            return $urandom_range(0, usual_hi);
        else
            return $urandom_range(0, hi);
    endfunction

    // The receiver: random stalls, full rate on request, and a long hold-off.
    initial
    begin
        int hold_cycles;
        int len;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++)
                    @(posedge clk);
                hold_req = 1'b0;
            end else if (full_rate) begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
                len = pick_gap() + 1;
                repeat (len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    task automatic send_item(input int vel, input int range_mm);
        int gap;
        s_axis_tdata <= {3'b000, range_mm[DIST_W-1:0], vel[VEL_W-1:0]};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(vel[VEL_W-1:0], range_mm[DIST_W-1:0]);
        gap = full_rate ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input int en, input int vmax, input int decel,
                              input int scale, input int buffer, input int vmin);
        write_reg(REG_ENABLE, CFG_W'(en));
        write_reg(REG_MAX_SPEED, CFG_W'(vmax));
        write_reg(REG_MAX_DECEL, CFG_W'(decel));
        write_reg(REG_SCALE, CFG_W'(scale));
        write_reg(REG_BUFFER, CFG_W'(buffer));
        write_reg(REG_MIN_SPEED, CFG_W'(vmin));
        cfg_wen <= 1'b0;
    endtask

    task automatic random_phase(input int n_items, input bit burst, input bit with_hold);
        set_config(($urandom_range(0, 9) != 0), pick_field(32767, 3000),
                   pick_field(65535, 3000), pick_field(65535, 1024),
                   ($urandom_range(0, 2) == 0) ? pick_field(DIST_MAX, 2000) : 0,
                   ($urandom_range(0, 2) == 0) ? pick_field(32767, 300) : 0);
        full_rate = burst;
        for (int i = 0; i < n_items; i++) begin
            if (with_hold && i == 20)
                hold_req = 1'b1;
            send_item(pick_velocity(), pick_distance(sb.slowdown_mm()));
        end
        drain();
        full_rate = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_wen <= 1'b0;
        cfg_index <= REG_ENABLE;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Limiter disabled after reset: commands pass through.
        send_item(32767, 100);
        send_item(-32768, 0);
        drain();

        set_config(1, 1000, 500, 256, 0, 0);
        send_item(1000, -1);
        send_item(1000, -1048576);
        send_item(1000, 1001);
        send_item(1000, 1000);
        send_item(500, 1000);
        send_item(32767, 0);
        send_item(-32768, 500);
        send_item(0, 10);
        send_item(-1, 1000000);
        send_item(-32768, 1048575);
        drain();

        // Oversized register data, zero deceleration and the top of every range.
        set_config(1, 20'hFFFFF, 0, 65535, DIST_MAX, 32767);
        write_reg(REG_SPARE_LO, 20'hABCDE);
        write_reg(REG_SPARE_HI, 20'h00000);
        cfg_wen <= 1'b0;
        send_item(32767, 1048575);
        send_item(-32768, 1048575);
        send_item(-5, 3);
        send_item(12345, 0);
        drain();

        set_config(1, 0, 65535, 0, 0, 0);
        send_item(100, 0);
        send_item(100, 1);
        send_item(-32768, 0);
        drain();

        set_config(1, 32767, 65535, 256, DIST_MAX, 100);
        send_item(-32768, 1048575);
        send_item(32767, 1048575);
        send_item(50, 0);
        send_item(150, 1);
        drain();

        for (int p = 0; p < 8; p++)
            random_phase(200, (p == 3), (p == 1));

        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
